// ===== design/gci_pkg.sv =====
`default_nettype none

package gci_pkg;

    localparam int FW_W       = 13;   // frame width / column width
    localparam int CH_W       = 16;   // Q0.16 channel
    localparam int BYTE_W     = 8;
    localparam int NCH        = 3;    // red, green, blue lanes
    localparam int OP_W       = 2;
    localparam int ST_W       = 2;
    localparam int BDIV_STEPS = 8;    // one quotient bit per step, result below 256
    localparam int PROD_W     = CH_W + FW_W;
    localparam int SUM_W      = 31;   // holds 2*S + 257*den
    localparam int BYTE_SCALE = 257;  // 65535 / 255

    localparam logic [FW_W-1:0] FW_RESET = 13'd1080;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic            accept;     // item taken this cycle, latch status
        logic [ST_W-1:0] status;
        logic            append;
        logic            clear;
        logic            q_start;
        logic            idiv_step;
        logic            rd0;
        logic            rd1;
        logic            mul;
        logic            sum;
        logic            bdiv_step;
        logic            emit;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== design/gci_ctrl.sv =====
`default_nettype none

module gci_ctrl #(
    parameter int AW = 12
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    input  wire [gci_pkg::OP_W-1:0]  i_op,
    input  gci_pkg::t_sts            i_sts,
    output logic                     o_in_ready,
    output gci_pkg::t_cmd            o_cmd
);

    localparam int STEPS_MAX = (AW > gci_pkg::BDIV_STEPS) ? AW : gci_pkg::BDIV_STEPS;
    localparam int CW        = $clog2(STEPS_MAX);

    typedef enum logic [2:0] {
        S_IDLE, S_IDIV, S_RD0, S_RD1, S_MUL, S_SUM, S_BDIV, S_EMIT
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            w_acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        o_cmd.status = gci_pkg::ST_OK;
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EMIT;
                    unique case (i_op)
                        gci_pkg::OP_APPEND: begin
                            if (i_sts.full) begin
                                o_cmd.status = gci_pkg::ST_FULL;
                            end else begin
                                o_cmd.append = 1'b1;
                            end
                        end
                        gci_pkg::OP_QUERY: begin
                            if (i_sts.empty) begin
                                o_cmd.status = gci_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.q_start = 1'b1;
                                n_cnt         = CW'(AW - 1);
                                n_state       = S_IDIV;
                            end
                        end
                        gci_pkg::OP_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_IDIV: begin
                o_cmd.idiv_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_RD0;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            S_RD0: begin
                o_cmd.rd0 = 1'b1;
                n_state   = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd1 = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_cnt     = CW'(gci_pkg::BDIV_STEPS - 1);
                n_state   = S_BDIV;
            end
            S_BDIV: begin
                o_cmd.bdiv_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_EMIT;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            S_EMIT: begin
                // hold the finished item until the output slot frees up
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== design/gci_datapath.sv =====
`default_nettype none

module gci_datapath #(
    parameter int HISTORY_DEPTH = 4096
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  gci_pkg::t_cmd                    i_cmd,
    output gci_pkg::t_sts                    o_sts,
    input  wire                              i_cfg_we,
    input  wire [gci_pkg::FW_W-1:0]          i_cfg_data,
    input  wire [gci_pkg::FW_W-1:0]          i_col,
    input  wire [gci_pkg::CH_W-1:0]          i_red,
    input  wire [gci_pkg::CH_W-1:0]          i_green,
    input  wire [gci_pkg::CH_W-1:0]          i_blue,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [gci_pkg::BYTE_W-1:0]       o_red_byte,
    output logic [gci_pkg::BYTE_W-1:0]       o_green_byte,
    output logic [gci_pkg::BYTE_W-1:0]       o_blue_byte,
    output logic [gci_pkg::ST_W-1:0]         o_status
);

    localparam int FW_W   = gci_pkg::FW_W;
    localparam int CH_W   = gci_pkg::CH_W;
    localparam int BW     = gci_pkg::BYTE_W;
    localparam int NCH    = gci_pkg::NCH;
    localparam int PW     = gci_pkg::PROD_W;
    localparam int SW     = gci_pkg::SUM_W;
    localparam int AW     = $clog2(HISTORY_DEPTH);
    localparam int CNTW   = $clog2(HISTORY_DEPTH + 1);
    localparam int NUMW   = FW_W + AW;
    localparam int ENT_W  = NCH * CH_W;

    logic [ENT_W-1:0]  mem [HISTORY_DEPTH];

    logic [FW_W-1:0]   r_fw;
    logic [CNTW-1:0]   r_count;
    logic [FW_W-1:0]   r_den;
    logic [NUMW-1:0]   r_irem;
    logic [NUMW-1:0]   r_idv;
    logic [AW-1:0]     r_iquo;
    logic [AW-1:0]     r_i1;
    logic [FW_W-1:0]   r_r;
    logic [ENT_W-1:0]  r_rd;
    logic [ENT_W-1:0]  r_c0;
    logic [PW-1:0]     r_p0 [NCH];
    logic [PW-1:0]     r_p1 [NCH];
    logic [SW-1:0]     r_brem [NCH];
    logic [SW-1:0]     r_bdv;
    logic [BW-1:0]     r_bquo [NCH];
    logic [gci_pkg::ST_W-1:0] r_st;
    logic              r_isq;
    logic              r_ov;
    logic [BW-1:0]     r_out [NCH];
    logic [gci_pkg::ST_W-1:0] r_out_st;

    logic [CNTW-1:0]   w_cm1;
    logic [AW-1:0]     w_last;
    logic              w_small;
    logic [FW_W-1:0]   w_den_in;
    logic [FW_W-1:0]   w_colc;
    logic [NUMW-1:0]   w_num;
    logic              w_ige;
    logic              w_iclamp;
    logic [AW-1:0]     w_i0;
    logic [AW-1:0]     w_raddr;
    logic [FW_W-1:0]   w_wa;
    logic [SW-1:0]     w_q;

    assign w_cm1    = r_count - CNTW'(1);
    assign w_last   = w_cm1[AW-1:0];
    assign w_small  = (r_fw <= FW_W'(1));
    assign w_den_in = w_small ? FW_W'(1) : (r_fw - FW_W'(1));
    assign w_colc   = (i_col > w_den_in) ? w_den_in : i_col;
    assign w_num    = w_small ? '0 : (NUMW'(w_colc) * NUMW'(w_last));

    assign w_ige    = (r_irem >= r_idv);
    assign w_iclamp = (r_iquo >= w_last);
    assign w_i0     = w_iclamp ? w_last : r_iquo;
    assign w_raddr  = i_cmd.rd1 ? r_i1 : w_i0;
    assign w_wa     = r_den - r_r;
    assign w_q      = SW'(r_den) * SW'(gci_pkg::BYTE_SCALE);

    assign o_sts.full     = (r_count == CNTW'(HISTORY_DEPTH));
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.out_free = !r_ov || i_out_ready;

    // history memory: one write port (append), one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            mem[r_count[AW-1:0]] <= {i_blue, i_green, i_red};
        end
        if (i_cmd.rd0 || i_cmd.rd1) begin
            r_rd <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw    <= gci_pkg::FW_RESET;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fw <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.append) begin
                r_count <= r_count + CNTW'(1);
            end
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_st  <= i_cmd.status;
            r_isq <= i_cmd.q_start;
        end
        // column position: num / den, one quotient bit a cycle
        if (i_cmd.q_start) begin
            r_den  <= w_den_in;
            r_irem <= w_num;
            r_idv  <= NUMW'(w_den_in) << (AW - 1);
            r_iquo <= '0;
        end
        if (i_cmd.idiv_step) begin
            if (w_ige) begin
                r_irem <= r_irem - r_idv;
            end
            r_iquo <= (r_iquo << 1) | AW'(w_ige);
            r_idv  <= r_idv >> 1;
        end
        if (i_cmd.rd0) begin
            r_r  <= w_iclamp ? '0 : r_irem[FW_W-1:0];
            r_i1 <= (w_i0 == w_last) ? w_last : (w_i0 + AW'(1));
        end
        if (i_cmd.rd1) begin
            r_c0 <= r_rd;
        end
        for (int ch = 0; ch < NCH; ch++) begin
            if (i_cmd.mul) begin
                r_p0[ch] <= PW'(r_c0[ch*CH_W +: CH_W]) * PW'(w_wa);
                r_p1[ch] <= PW'(r_rd[ch*CH_W +: CH_W]) * PW'(r_r);
            end
            // byte = floor((2S + q) / 2q), q = 257*den
            if (i_cmd.sum) begin
                r_brem[ch] <= ((SW'(r_p0[ch]) + SW'(r_p1[ch])) << 1) + w_q;
                r_bquo[ch] <= '0;
            end
            if (i_cmd.bdiv_step) begin
                if (r_brem[ch] >= r_bdv) begin
                    r_brem[ch] <= r_brem[ch] - r_bdv;
                end
                r_bquo[ch] <= (r_bquo[ch] << 1) | BW'(r_brem[ch] >= r_bdv);
            end
            if (i_cmd.emit) begin
                r_out[ch] <= r_isq ? r_bquo[ch] : '0;
            end
        end
        if (i_cmd.sum) begin
            r_bdv <= w_q << gci_pkg::BDIV_STEPS;
        end
        if (i_cmd.bdiv_step) begin
            r_bdv <= r_bdv >> 1;
        end
        if (i_cmd.emit) begin
            r_out_st <= r_st;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_red_byte   = r_out[0];
    assign o_green_byte = r_out[1];
    assign o_blue_byte  = r_out[2];
    assign o_status     = r_out_st;

endmodule

`default_nettype wire

// ===== design/gradient_column_interpolator_unit.sv =====
// Gradient column interpolator: keeps a history of Q0.16 RGB colors (one per frame) and
// answers column queries with the linear blend at position x*(N-1)/(W-1), rounded to bytes.
// One item in flight at a time; every item yields exactly one result. In a query the
// position divide produces one index bit per cycle, two reads share the single history
// memory port, then a multiply, a sum and an 8-step rounding divide run on all three
// channels in parallel. A result waiting in the output register does not block the next
// item; only its own hand-off waits for the slot. The user must write frame_width only
// while idle; the block itself does not enforce it. The history count resets to zero;
// entries need no clearing.
`default_nettype none

module gradient_column_interpolator_unit #(
    parameter int HISTORY_DEPTH = 4096
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [12:0]  i_cfg_data,      // frame_width
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [63:0]  s_axis_tdata,    // column[12:0], red_in[28:13], green_in[44:29],
                                         // blue_in[60:45], zero[63:61]
    input  wire [1:0]   s_axis_tuser,    // operation[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,    // red_byte[7:0], green_byte[15:8], blue_byte[23:16]
    output logic [1:0]  m_axis_tuser     // status[1:0]
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    gci_pkg::t_cmd  w_cmd;
    gci_pkg::t_sts  w_sts;
    logic [7:0]     w_red, w_green, w_blue;

    assign o_cfg_ready = 1'b1;

    gci_ctrl #(
        .AW (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (s_axis_tuser),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    gci_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_col        (s_axis_tdata[12:0]),
        .i_red        (s_axis_tdata[28:13]),
        .i_green      (s_axis_tdata[44:29]),
        .i_blue       (s_axis_tdata[60:45]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_red_byte   (w_red),
        .o_green_byte (w_green),
        .o_blue_byte  (w_blue),
        .o_status     (m_axis_tuser)
    );

    assign m_axis_tdata = {w_blue, w_green, w_red};

endmodule

`default_nettype wire

// ===== design/gci_checker.sv =====
`default_nettype none

module gci_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata,
    input wire [1:0]  m_axis_tuser
);

    // one item at a time: the input closes right after an item is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready stayed high after an accepted item");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == gci_pkg::ST_OK
                           || m_axis_tuser == gci_pkg::ST_EMPTY
                           || m_axis_tuser == gci_pkg::ST_FULL))
        else $error("unknown status code on output");

    // empty-history and full-store results carry black
    a_err_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != gci_pkg::ST_OK) |-> (m_axis_tdata == 24'd0))
        else $error("error result with nonzero color");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("stalled output item changed");

endmodule

bind gradient_column_interpolator_unit gci_checker u_gci_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== tb/gradient_column_interpolator_unit_tb.sv =====
`timescale 1ns / 1ps

module gradient_column_interpolator_unit_tb;

    localparam int OP_W        = gci_pkg::OP_W;
    localparam int ST_W        = gci_pkg::ST_W;
    localparam int CH_W        = gci_pkg::CH_W;
    localparam int FW_W        = gci_pkg::FW_W;
    localparam int BYTE_W      = gci_pkg::BYTE_W;
    localparam int HIST_DEPTH  = 4096;
    localparam int PHASE_ITEMS = 140;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 40;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [ST_W-1:0]   status;
    } t_color_result;

    // Tracks the color history and span, and holds the colors still owed by the block.
    class column_blend_tracker;
        logic [CH_W-1:0] red_hist   [HIST_DEPTH];
        logic [CH_W-1:0] green_hist [HIST_DEPTH];
        logic [CH_W-1:0] blue_hist  [HIST_DEPTH];
        int unsigned     n_stored;
        logic [FW_W-1:0] span;
        t_color_result   pending_colors[$];
        int              failures;
        int              queries;
        int              drops;
        int              empties;

        function new();
            n_stored = 0;
            span     = gci_pkg::FW_RESET;
            failures = 0;
            queries  = 0;
            drops    = 0;
            empties  = 0;
        endfunction

        function void set_span(logic [FW_W-1:0] w);
            span = w;
        endfunction

        // blended Q0.16 value scaled to a byte, rounded half up
        function logic [BYTE_W-1:0] round_byte(longint unsigned c0, longint unsigned c1,
                                               longint unsigned den, longint unsigned rem);
            longint unsigned s;
            longint unsigned q;
            longint unsigned b;
            s = c0 * (den - rem) + c1 * rem;
            q = gci_pkg::BYTE_SCALE * den;
            b = (2 * s + q) / (2 * q);
            return (b > 255) ? 8'hFF : b[7:0];
        endfunction

        function void take_item(logic [OP_W-1:0] op, logic [FW_W-1:0] col,
                                logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
            t_color_result   res;
            longint unsigned last;
            longint unsigned den;
            longint unsigned num;
            longint unsigned c;
            longint unsigned i0;
            longint unsigned i1;
            longint unsigned rem;
            res = '0;
            res.status = gci_pkg::ST_OK;
            case (op)
                gci_pkg::OP_APPEND: begin
                    if (n_stored >= HIST_DEPTH) begin
                        res.status = gci_pkg::ST_FULL;
                        drops++;
                    end else begin
                        red_hist[n_stored]   = r;
                        green_hist[n_stored] = g;
                        blue_hist[n_stored]  = b;
                        n_stored++;
                    end
                end
                gci_pkg::OP_CLEAR: begin
                    n_stored = 0;
                end
                gci_pkg::OP_QUERY: begin
                    queries++;
                    if (n_stored == 0) begin
                        res.status = gci_pkg::ST_EMPTY;
                        empties++;
                    end else begin
                        last = n_stored - 1;
                        if (span <= 1) begin
                            den = 1;
                            num = 0;
                        end else begin
                            den = span - 1;
                            c = (col > den) ? den : col;
                            num = c * last;
                        end
                        i0  = num / den;
                        rem = num % den;
                        if (i0 >= last) begin
                            i0  = last;
                            rem = 0;
                        end
                        i1 = (i0 + 1 > last) ? last : i0 + 1;
                        res.red   = round_byte(red_hist[i0], red_hist[i1], den, rem);
                        res.green = round_byte(green_hist[i0], green_hist[i1], den, rem);
                        res.blue  = round_byte(blue_hist[i0], blue_hist[i1], den, rem);
                    end
                end
                default: ;
            endcase
            pending_colors.insert(pending_colors.size(), res);
        endfunction

        function void match_result(logic [23:0] data, logic [ST_W-1:0] user);
            t_color_result want;
            t_color_result got;
            got.red    = data[7:0];
            got.green  = data[15:8];
            got.blue   = data[23:16];
            got.status = user;
            if (pending_colors.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected result r=%0d g=%0d b=%0d st=%0d",
                             $realtime, got.red, got.green, got.blue, got.status);
                return;
            end
            want = pending_colors.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.status !== want.status) begin
                failures++;
                if (failures <= 10)
                    $display({"%0t: mismatch exp r=%0d g=%0d b=%0d st=%0d, ",
                              "got r=%0d g=%0d b=%0d st=%0d"},
                             $realtime, want.red, want.green, want.blue, want.status,
                             got.red, got.green, got.blue, got.status);
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic [FW_W-1:0]   i_cfg_data    = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata  = '0;
    logic [OP_W-1:0]   s_axis_tuser  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;
    logic [ST_W-1:0]   m_axis_tuser;

    column_blend_tracker sb = new();

    int send_idle_pct = 18;
    int recv_idle_pct = 86;
    int stuck_cycles  = 0;
    int items_sent    = 0;
    int span_writes   = 0;

    gradient_column_interpolator_unit #(
        .HISTORY_DEPTH(HIST_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.match_result(m_axis_tdata, m_axis_tuser);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
            $display("gradient_column_interpolator_unit_tb: FAIL");
            $finish;
        end
    end

    // called at a clock edge; returns at the edge where the item was taken, tvalid still high
    task automatic send_item(input logic [OP_W-1:0] op, input logic [FW_W-1:0] col,
                             input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                             input logic [CH_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, b, g, r, col};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_item(op, col, r, g, b);
        items_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_colors.size() != 0);
    endtask

    task automatic write_span(input logic [FW_W-1:0] w);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_span(w);
        span_writes++;
    endtask

    function automatic logic [CH_W-1:0] pick_channel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return CH_W'($urandom);
        endcase
    endfunction

    function automatic logic [FW_W-1:0] pick_column();
        logic [FW_W-1:0] edge_col;
        edge_col = (sb.span == 0) ? '0 : sb.span - 1'b1;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return edge_col;
            2:       return FW_W'($urandom_range(0, 8191));
            default: return (sb.span <= 1) ? FW_W'($urandom_range(0, 8191))
                                           : FW_W'($urandom_range(0, sb.span - 1));
        endcase
    endfunction

    // returns 0 for an unused code, which the block answers with an OK status and black
    task automatic random_item(output bit counted);
        int              pick;
        logic [OP_W-1:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 45)      op = gci_pkg::OP_APPEND;
        else if (pick < 92) op = gci_pkg::OP_QUERY;
        else if (pick < 97) op = gci_pkg::OP_CLEAR;
        else                op = OP_UNUSED;
        if ($urandom_range(0, 99) == 0)
            drain_results();
        send_item(op, pick_column(), pick_channel(), pick_channel(), pick_channel());
        counted = (op != OP_UNUSED);
    endtask

    task automatic random_phase(input logic [FW_W-1:0] w);
        int n;
        bit counted;
        write_span(w);
        n = 0;
        while (n < PHASE_ITEMS) begin
            random_item(counted);
            if (counted)
                n++;
        end
    endtask

    initial begin
        logic [FW_W-1:0] spans [8];
        int i;
        spans = '{13'd320, 13'd7680, 13'd0, 13'd1, 13'd2, 13'd8191,
                  FW_W'($urandom_range(320, 7680)), 13'd1080};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset span
        send_item(gci_pkg::OP_QUERY, 13'd0, '0, '0, '0);
        send_item(OP_UNUSED, 13'h1FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(gci_pkg::OP_CLEAR, '0, '0, '0, '0);
        send_item(gci_pkg::OP_APPEND, '0, 16'h0000, 16'h0000, 16'h0000);
        send_item(gci_pkg::OP_QUERY, 13'd500, '0, '0, '0);
        send_item(gci_pkg::OP_APPEND, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(gci_pkg::OP_QUERY, 13'd0, '0, '0, '0);
        send_item(gci_pkg::OP_QUERY, 13'd1079, '0, '0, '0);
        send_item(gci_pkg::OP_QUERY, 13'd540, '0, '0, '0);
        send_item(gci_pkg::OP_QUERY, 13'h1FFF, '0, '0, '0);
        send_item(gci_pkg::OP_QUERY, 13'd7679, '0, '0, '0);
        send_item(gci_pkg::OP_APPEND, '0, 16'h5555, 16'hAAAA, 16'h8000);
        send_item(gci_pkg::OP_QUERY, 13'd539, '0, '0, '0);
        send_item(gci_pkg::OP_QUERY, 13'd540, '0, '0, '0);
        send_item(gci_pkg::OP_QUERY, 13'd1078, '0, '0, '0);
        send_item(gci_pkg::OP_CLEAR, '0, '0, '0, '0);
        send_item(gci_pkg::OP_QUERY, 13'd0, '0, '0, '0);
        send_item(gci_pkg::OP_APPEND, '0, 16'hAAAA, 16'h5555, 16'h7FFF);
        send_item(gci_pkg::OP_QUERY, 13'd1079, '0, '0, '0);
        send_item(gci_pkg::OP_APPEND, '0, 16'h0101, 16'hFEFE, 16'h0080);
        send_item(gci_pkg::OP_QUERY, 13'd270, '0, '0, '0);

        for (i = 0; i < 8; i++) begin
            if (i == 3) begin
                send_idle_pct = 86;
                recv_idle_pct = 18;
            end else if (i == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_phase(spans[i]);
        end

        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("run: %0d items, %0d frame_width writes incl. 0, 1, 2, 320, 7680, 8191",
                 items_sent, span_writes);
        $display("run: %0d queries (%0d on empty history), %0d appends dropped on full store",
                 sb.queries, sb.empties, sb.drops);
        if (sb.failures == 0) begin
            $display("gradient_column_interpolator_unit_tb: PASS");
        end else begin
            $display("%0d failures", sb.failures);
            $display("gradient_column_interpolator_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/gci_pkg.sv
design/gci_ctrl.sv
design/gci_datapath.sv
design/gradient_column_interpolator_unit.sv
design/gci_checker.sv
tb/gradient_column_interpolator_unit_tb.sv
